// ===== sv/ekvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ekvt_pkg;

	localparam int ENTRIES_DEF   = 16;
	localparam int KEY_BITS_DEF  = 32;
	localparam int DATA_BITS_DEF = 32;

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	typedef struct packed {
		logic        func;
		logic [31:0] key;
		logic [31:0] data_in;
		logic [31:0] time_req;
		logic [31:0] lifetime;
	} in_beat_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] data_out;
		logic        dropped;
		logic [4:0]  record_count;
	} out_beat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic match;
		logic miss;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== sv/ekvt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ekvt_ctrl
	import ekvt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.match || sts.miss) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.start = req_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
			end
			ST_OUT: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/ekvt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ekvt_dp
	import ekvt_pkg::*;
#(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF,
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cmd_t     cmd,
	output sts_t          sts,
	input  wire in_beat_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output out_beat_t     rsp
);

	localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int DW = (DATA_BITS < 32) ? DATA_BITS : 32;
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	typedef struct packed {
		logic [KW-1:0] key;
		logic [31:0]   arrival;
		logic [31:0]   life;
		logic [DW-1:0] data;
	} rec_t;

	rec_t mem [ENTRIES];

	in_beat_t      req_q;
	logic [CW-1:0] idx_q;
	logic          pend_q;
	logic [AW-1:0] ridx_q;
	rec_t          rd_q;
	logic          found_q;
	logic [AW-1:0] slot_q;
	logic [CW-1:0] fill_q;
	out_beat_t     res_q;
	out_beat_t     rsp_q;
	logic          rsp_valid_q;

	logic [KW-1:0] req_key;
	logic          match;
	logic          more;
	logic          rd_en;
	logic          is_lookup;
	logic          full;
	logic          later;
	logic          live;
	logic [32:0]   end_sum;
	logic          insert;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	rec_t          wr_rec;
	logic [CW-1:0] fill_after;
	out_beat_t     res_d;

	assign req_key   = KW'(req_q.key);
	assign match     = pend_q && (rd_q.key == req_key);
	assign more      = idx_q < fill_q;
	assign rd_en     = cmd.scan && !match && more;
	assign is_lookup = (req_q.func == FUNC_LOOKUP);
	assign full      = (fill_q == CW'(ENTRIES));
	assign later     = req_q.time_req > rd_q.arrival;
	assign end_sum   = {1'b0, rd_q.arrival} + {1'b0, rd_q.life};
	assign live      = (rd_q.arrival <= req_q.time_req) && ({1'b0, req_q.time_req} < end_sum);
	assign insert    = cmd.commit && !is_lookup && !found_q && !full;
	assign wr_en     = insert || (cmd.commit && !is_lookup && found_q && later);
	assign wr_addr   = found_q ? slot_q : fill_q[AW-1:0];
	assign fill_after = insert ? (fill_q + 1'b1) : fill_q;

	always_comb begin
		wr_rec.key     = req_key;
		wr_rec.arrival = req_q.time_req;
		wr_rec.life    = req_q.lifetime;
		wr_rec.data    = DW'(req_q.data_in);

		res_d.hit          = is_lookup && found_q && live;
		res_d.data_out     = res_d.hit ? 32'(rd_q.data) : 32'd0;
		res_d.dropped      = !is_lookup && !found_q && full;
		res_d.record_count = 5'(fill_after);
	end

	assign sts.match    = match;
	assign sts.miss     = !match && !more;
	assign sts.out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_rec;
		end
		if (rd_en) begin
			rd_q <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			pend_q      <= 1'b0;
			found_q     <= 1'b0;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				idx_q   <= '0;
				pend_q  <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.scan) begin
				pend_q <= rd_en;
				if (rd_en) begin
					idx_q <= idx_q + 1'b1;
				end
				if (match) begin
					found_q <= 1'b1;
				end
			end
			if (insert) begin
				fill_q <= fill_after;
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= req;
		end
		if (rd_en) begin
			ridx_q <= idx_q[AW-1:0];
		end
		if (cmd.scan && match) begin
			slot_q <= ridx_q;
		end
		if (cmd.commit) begin
			res_q <= res_d;
		end
		if (cmd.load_out) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== sv/expiring_key_value_table_unit.sv =====
// Expiring key/value table. A request beat on req (valid/stall) either updates
// or inserts a record (func update) or looks a key up at a given time (func
// lookup). Every request gives exactly one response beat on rsp, which carries
// hit, the data of a live record, the dropped flag for a new key refused by a
// full table, and the number of records held after the request.
// The request is searched against the held records one record per cycle
// through the record memory, followed by a commit cycle that writes the
// memory and forms the response. The search stops at the first record whose
// key matches, so the response comes sooner when the key sits early in the
// table; a key that is not held is checked against every held record. The
// memory read port, one read per cycle during the search, sets how long the
// search takes and so how often the block can take a new request.
// A request is taken while an earlier response still waits in the output
// register; the new response waits in the block until that one is taken.
// req_stall is high from the accepting edge until the response is loaded.
// When the receiver holds rsp_stall, the response beat stays unchanged.
// Reset empties the table and drops any pending response; no clearing pass
// is needed, so requests are taken in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module expiring_key_value_table_unit
	import ekvt_pkg::*;
#(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int KEY_BITS  = KEY_BITS_DEF,
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire in_beat_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output out_beat_t     rsp
);

	cmd_t cmd;
	sts_t sts;

	ekvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ekvt_dp #(
		.ENTRIES   (ENTRIES),
		.KEY_BITS  (KEY_BITS),
		.DATA_BITS (DATA_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== sv/ekvt_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ekvt_chk
	import ekvt_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_valid,
	input wire logic      req_stall,
	input wire logic      rsp_valid,
	input wire logic      rsp_stall,
	input wire out_beat_t rsp
);

	// A stalled response beat holds its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// The block works on one request at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in progress");

	// Data is only reported by a hit.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.data_out == 32'd0)
		else $error("data reported without a hit");

	// Refusal only happens with a full table, and never together with a hit.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.dropped |-> !rsp.hit && rsp.record_count == 5'(ENTRIES))
		else $error("update dropped while the table was not full");

endmodule

bind expiring_key_value_table_unit ekvt_chk #(.ENTRIES(ENTRIES)) u_chk (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import ekvt_pkg::*;

	localparam int POOL_SIZE   = 20;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SCAN_CYCLES = ENTRIES_DEF + 4;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PATTERN
	} stall_mode_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_beat_t  req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_beat_t rsp;

	expiring_key_value_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// Shadow copy of the record table.
	logic [31:0] tbl_key [ENTRIES_DEF];
	logic [31:0] tbl_arrival [ENTRIES_DEF];
	logic [31:0] tbl_lifetime [ENTRIES_DEF];
	logic [31:0] tbl_data [ENTRIES_DEF];
	logic [4:0]  tbl_fill = '0;

	out_beat_t   expected_rsp [$];
	out_beat_t   want;
	int          error_count = 0;
	int          items_sent = 0;
	int          results_checked = 0;
	int          lookups_seen = 0;
	int          hits_seen = 0;
	int          drops_seen = 0;
	int          cycle_count = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int          hold_req = 0;
	int          hold_left = 0;
	int          pattern_pos = 0;

	logic [31:0] pool_key [POOL_SIZE];
	logic [31:0] pool_time [POOL_SIZE];
	logic [31:0] pool_life [POOL_SIZE];
	bit          pool_set [POOL_SIZE];
	logic [31:0] now_time;

	function automatic out_beat_t predict_response(input in_beat_t b);
		out_beat_t   r;
		int          slot;
		logic [32:0] expiry;
		r = '0;
		slot = -1;
		for (int i = 0; i < tbl_fill; i++) begin
			if (slot < 0 && tbl_key[i] == b.key) begin
				slot = i;
			end
		end
		if (b.func == FUNC_UPDATE) begin
			if (slot < 0) begin
				if (tbl_fill < ENTRIES_DEF) begin
					tbl_key[tbl_fill] = b.key;
					tbl_arrival[tbl_fill] = b.time_req;
					tbl_lifetime[tbl_fill] = b.lifetime;
					tbl_data[tbl_fill] = b.data_in;
					tbl_fill = tbl_fill + 5'd1;
				end else begin
					r.dropped = 1'b1;
				end
			end else if (b.time_req > tbl_arrival[slot]) begin
				tbl_arrival[slot] = b.time_req;
				tbl_lifetime[slot] = b.lifetime;
				tbl_data[slot] = b.data_in;
			end
		end else if (slot >= 0) begin
			expiry = {1'b0, tbl_arrival[slot]} + {1'b0, tbl_lifetime[slot]};
			if (b.time_req >= tbl_arrival[slot] && {1'b0, b.time_req} < expiry) begin
				r.hit = 1'b1;
				r.data_out = tbl_data[slot];
			end
		end
		r.record_count = tbl_fill;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: response beat with nothing outstanding: hit=%0b data=%h dropped=%0b count=%0d",
						$time, rsp.hit, rsp.data_out, rsp.dropped, rsp.record_count);
					error_count++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.hit !== want.hit || rsp.data_out !== want.data_out ||
						rsp.dropped !== want.dropped || rsp.record_count !== want.record_count) begin
						$display("%0t: mismatch: expected hit=%0b data=%h dropped=%0b count=%0d",
							$time, want.hit, want.data_out, want.dropped, want.record_count);
						$display("%0t:           actual hit=%0b data=%h dropped=%0b count=%0d",
							$time, rsp.hit, rsp.data_out, rsp.dropped, rsp.record_count);
						error_count++;
					end
					if (want.hit) hits_seen++;
					if (want.dropped) drops_seen++;
					results_checked++;
				end
			end
			if (req_valid === 1'b1 && req_stall === 1'b0) begin
				if (req.func == FUNC_LOOKUP) lookups_seen++;
				expected_rsp = {expected_rsp, predict_response(req)};
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE: rsp_stall <= 1'b0;
				STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 25);
				STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 75);
				STALL_PATTERN: begin
					rsp_stall <= (pattern_pos < 3);
					pattern_pos = (pattern_pos + 1) % 7;
				end
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("testbench failed");
			$finish;
		end
	end

	function automatic in_beat_t mk_beat(input logic f, input logic [31:0] k,
		input logic [31:0] d, input logic [31:0] t, input logic [31:0] l);
		in_beat_t b;
		b.func = f;
		b.key = k;
		b.data_in = d;
		b.time_req = t;
		b.lifetime = l;
		return b;
	endfunction

	function automatic in_beat_t next_random_item();
		in_beat_t    b;
		int          idx;
		int          pick;
		logic [31:0] arr;
		logic [31:0] life;
		b.data_in = $urandom;
		b.lifetime = $urandom;
		b.time_req = $urandom;
		idx = $urandom_range(0, POOL_SIZE - 1);
		arr = pool_time[idx];
		life = pool_life[idx];
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			b.func = FUNC_UPDATE;
			b.key = pool_key[idx];
			case ($urandom_range(0, 9))
				0: b.time_req = arr;
				1: b.time_req = arr - $urandom_range(1, 4);
				2: b.time_req = $urandom;
				default: begin
					now_time = now_time + $urandom_range(0, 40);
					b.time_req = now_time;
				end
			endcase
			case ($urandom_range(0, 19))
				0: b.lifetime = '0;
				1: b.lifetime = 32'hFFFF_FFFF;
				2, 3, 4, 5: b.lifetime = $urandom;
				default: b.lifetime = $urandom_range(1, 40);
			endcase
			if (!pool_set[idx] || b.time_req > arr) begin
				pool_set[idx] = 1'b1;
				pool_time[idx] = b.time_req;
				pool_life[idx] = b.lifetime;
			end
		end else if (pick < 90) begin
			b.func = FUNC_LOOKUP;
			b.key = pool_key[idx];
			if (pool_set[idx]) begin
				case ($urandom_range(0, 5))
					0: b.time_req = arr - 1;
					1: b.time_req = arr;
					2: b.time_req = arr + life - 1;
					3: b.time_req = arr + life;
					4: b.time_req = arr + $urandom_range(0, life);
					default: b.time_req = now_time + $urandom_range(0, 60);
				endcase
			end
		end else begin
			b.func = $urandom_range(0, 1);
			b.key = $urandom;
		end
		return b;
	endfunction

	task automatic send_beat(input in_beat_t b);
		req <= b;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall !== 1'b0) @(posedge clk);
		items_sent++;
	endtask

	task automatic wait_all_responses();
		req_valid <= 1'b0;
		do @(posedge clk); while (results_checked != items_sent);
	endtask

	task automatic test_directed_cases();
		stall_mode = STALL_LIGHT;
		send_beat(mk_beat(FUNC_LOOKUP, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
		send_beat(mk_beat(FUNC_UPDATE, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
		send_beat(mk_beat(FUNC_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0));
		send_beat(mk_beat(FUNC_LOOKUP, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0));
		send_beat(mk_beat(FUNC_UPDATE, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_beat(mk_beat(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0));
		send_beat(mk_beat(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFE, 32'h0));
		// Same arrival time as the stored record, so the record must stay as it is.
		send_beat(mk_beat(FUNC_UPDATE, 32'h0, 32'h1234_5678, 32'h0, 32'h5));
		send_beat(mk_beat(FUNC_LOOKUP, 32'h0, 32'h0, 32'h100, 32'h0));
		send_beat(mk_beat(FUNC_UPDATE, 32'h55, 32'hA5A5_5A5A, 32'd1000, 32'd10));
		send_beat(mk_beat(FUNC_LOOKUP, 32'h55, 32'h0, 32'd999, 32'h0));
		send_beat(mk_beat(FUNC_LOOKUP, 32'h55, 32'h0, 32'd1000, 32'h0));
		send_beat(mk_beat(FUNC_LOOKUP, 32'h55, 32'h0, 32'd1009, 32'h0));
		send_beat(mk_beat(FUNC_LOOKUP, 32'h55, 32'h0, 32'd1010, 32'h0));
		send_beat(mk_beat(FUNC_UPDATE, 32'h55, 32'h1111_1111, 32'd999, 32'd100));
		send_beat(mk_beat(FUNC_LOOKUP, 32'h55, 32'h0, 32'd1005, 32'h0));
		send_beat(mk_beat(FUNC_UPDATE, 32'h55, 32'h2222_2222, 32'd2000, 32'd0));
		send_beat(mk_beat(FUNC_LOOKUP, 32'h55, 32'h0, 32'd2000, 32'h0));
		send_beat(mk_beat(FUNC_UPDATE, 32'h55, 32'h3333_3333, 32'd2001, 32'd1));
		send_beat(mk_beat(FUNC_LOOKUP, 32'h55, 32'h0, 32'd2001, 32'h0));
		send_beat(mk_beat(FUNC_LOOKUP, 32'h55, 32'h0, 32'd2002, 32'h0));
		wait_all_responses();
	endtask

	task automatic test_random_traffic(input int count, input stall_mode_t mode,
		input int max_gap);
		int sent;
		int burst;
		int gap;
		stall_mode = mode;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			for (int j = 0; j < burst && sent < count; j++) begin
				send_beat(next_random_item());
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, max_gap);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		wait_all_responses();
	endtask

	task automatic test_output_hold_off();
		stall_mode = STALL_NONE;
		hold_req = 300;
		for (int j = 0; j < 40; j++) begin
			send_beat(next_random_item());
		end
		wait_all_responses();
	endtask

	initial begin
		pool_key[0] = 32'h0;
		pool_key[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++) begin
			pool_key[i] = $urandom;
		end
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_set[i] = 1'b0;
			pool_time[i] = '0;
			pool_life[i] = '0;
		end
		now_time = $urandom;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_traffic(400, STALL_LIGHT, 25);
		test_output_hold_off();
		test_random_traffic(350, STALL_HEAVY, 25);
		test_random_traffic(350, STALL_NONE, 0);
		test_random_traffic(300, STALL_PATTERN, 30);
		repeat (2 * SCAN_CYCLES) @(posedge clk);
		if (expected_rsp.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, expected_rsp.size());
			error_count++;
		end
		$display("Sent %0d requests and checked %0d responses under varied gaps and stalls.",
			items_sent, results_checked);
		$display("Lookups %0d with %0d hits; %0d inserts refused by a full table.",
			lookups_seen, hits_seen, drops_seen);
		if (error_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
